// File: hw/rtl/exhaustive_l1_nearest_neighbor_core_macros.svh
// assertion macros for the nearest neighbor core checker
// used by el1nn_chk only
`ifndef EXHAUSTIVE_L1_NEAREST_NEIGHBOR_CORE_MACROS_SVH
`define EXHAUSTIVE_L1_NEAREST_NEIGHBOR_CORE_MACROS_SVH

// same-cycle implication
`define EL1NN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EL1NN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/el1nn_pkg.sv
// shared types and constants for the nearest neighbor core
// no dependencies
package el1nn_pkg;

    localparam int SLOT_W     = 10;
    localparam int DIM_IN_W   = 7;
    localparam int COORD_IN_W = 16;
    localparam int ID_W       = 24;
    localparam int DIST_W     = 23;
    localparam int PTS_W      = 11;
    localparam int DIMS_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 1'b1;

    localparam logic [PTS_W-1:0]  POINTS_RST = 11'd0;
    localparam logic [DIMS_W-1:0] DIMS_RST   = 8'd128;

    typedef struct packed {
        logic                  we;
        logic [SLOT_W-1:0]     slot;
        logic [DIM_IN_W-1:0]   dim;
        logic [COORD_IN_W-1:0] coord;
        logic [ID_W-1:0]       id;
    } t_ref_wr;

    typedef struct packed {
        logic                  we;
        logic                  last;
        logic [DIM_IN_W-1:0]   dim;
        logic [COORD_IN_W-1:0] coord;
        logic [ID_W-1:0]       id;
    } t_qry_wr;

    typedef struct packed {
        logic vld;
        logic first;
        logic zero;
    } t_acc_ctl;

    typedef struct packed {
        logic [ID_W-1:0]   query_id;
        logic [ID_W-1:0]   nearest_id;
        logic [DIST_W-1:0] nearest_dist;
        logic              found;
    } t_result;

endpackage

// File: hw/rtl/el1nn_refmem.sv
// reference point store: coordinate memory and id memory, registered reads
// depends on el1nn_pkg
module el1nn_refmem #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 128,
    parameter int COORD_BITS = 16,
    localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16,
    localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int AW = (MAX_POINTS * MAX_DIMS > 1) ? $clog2(MAX_POINTS * MAX_DIMS) : 1
) (
    input  logic                  i_clk,
    input  el1nn_pkg::t_ref_wr    i_wr,
    input  logic [AW-1:0]         i_coord_addr,
    input  logic [PW-1:0]         i_id_addr,
    output logic [CW-1:0]         o_coord_rd,
    output logic [el1nn_pkg::ID_W-1:0] o_id_rd
);
    import el1nn_pkg::*;

    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [CW-1:0]   r_cmem [MAX_POINTS * MAX_DIMS];
    logic [ID_W-1:0] r_idmem [MAX_POINTS];
    logic [CW-1:0]   r_coord_rd;
    logic [ID_W-1:0] r_id_rd;
    logic            wr_ok;
    logic [AW-1:0]   wr_addr;
    logic [PW-1:0]   wr_slot;

    assign wr_ok   = i_wr.we && (32'(i_wr.slot) < MAX_POINTS) && (32'(i_wr.dim) < MAX_DIMS);
    assign wr_slot = PW'(i_wr.slot);
    assign wr_addr = AW'(32'(i_wr.slot) * 32'(MAX_DIMS)) + AW'(DW'(i_wr.dim));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_cmem[wr_addr]  <= i_wr.coord[CW-1:0];
            r_idmem[wr_slot] <= i_wr.id;
        end
        r_coord_rd <= r_cmem[i_coord_addr];
        r_id_rd    <= r_idmem[i_id_addr];
    end

    assign o_coord_rd = r_coord_rd;
    assign o_id_rd    = r_id_rd;

endmodule

// File: hw/rtl/el1nn_absacc.sv
// shared absolute difference and accumulate unit, two register stages
// depends on el1nn_pkg
module el1nn_absacc #(
    parameter int MAX_DIMS   = 128,
    parameter int COORD_BITS = 16,
    localparam int CW    = (COORD_BITS < 16) ? COORD_BITS : 16,
    localparam int SUM_W = CW + $clog2(MAX_DIMS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  el1nn_pkg::t_acc_ctl  i_ctl,
    input  logic [CW-1:0]        i_qry_coord,
    input  logic [CW-1:0]        i_ref_coord,
    output logic [SUM_W-1:0]     o_sum
);
    import el1nn_pkg::*;

    logic signed [CW:0] diff;
    logic [CW:0]        mag;
    logic [CW-1:0]      r_ad;
    t_acc_ctl           r_ctl;
    logic [SUM_W-1:0]   r_sum;

    assign diff = $signed({i_qry_coord[CW-1], i_qry_coord})
                - $signed({i_ref_coord[CW-1], i_ref_coord});
    assign mag  = diff[CW] ? (CW+1)'(-diff) : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ad <= i_ctl.zero ? '0 : mag[CW-1:0];
        if (r_ctl.vld) begin
            r_sum <= (r_ctl.first ? '0 : r_sum) + SUM_W'(r_ad);
        end
    end

    assign o_sum = r_sum;

endmodule

// File: hw/rtl/el1nn_seq.sv
// search sequencer: query buffer, point and dim counters, running minimum
// depends on el1nn_pkg
module el1nn_seq #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 128,
    parameter int COORD_BITS = 16,
    localparam int CW    = (COORD_BITS < 16) ? COORD_BITS : 16,
    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int AW    = (MAX_POINTS * MAX_DIMS > 1) ? $clog2(MAX_POINTS * MAX_DIMS) : 1,
    localparam int SUM_W = CW + $clog2(MAX_DIMS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  el1nn_pkg::t_qry_wr            i_qry,
    input  logic [el1nn_pkg::PTS_W-1:0]   i_points,
    input  logic [el1nn_pkg::DIMS_W-1:0]  i_dims,
    input  logic                          i_out_free,
    output logic                          o_busy,
    output logic [AW-1:0]                 o_coord_addr,
    output logic [PW-1:0]                 o_id_addr,
    input  logic [el1nn_pkg::ID_W-1:0]    i_id_rd,
    output logic [CW-1:0]                 o_qry_rd,
    output el1nn_pkg::t_acc_ctl           o_acc_ctl,
    input  logic [SUM_W-1:0]              i_sum,
    output logic                          o_res_vld,
    output el1nn_pkg::t_result            o_res
);
    import el1nn_pkg::*;

    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    typedef struct packed {
        logic vld;
        logic first;
        logic zero;
        logic last;
        logic fin;
    } t_tag;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_qmem [MAX_DIMS];
    logic [CW-1:0]    r_qrd;
    logic [ID_W-1:0]  r_qtag;
    logic [PW-1:0]    r_p;
    logic [DW-1:0]    r_d;
    logic [AW-1:0]    r_base;
    t_tag             r_s1, r_s2, r_s3;
    logic [ID_W-1:0]  r_id2, r_id3;
    logic             r_found;
    logic [SUM_W-1:0] r_best;
    logic [ID_W-1:0]  r_bid;

    logic [PTS_W-1:0]  np;
    logic [DIMS_W-1:0] nd;
    logic              nd_zero, d_last, p_last, start, better;
    logic [CMP_W-1:0]  dist_ext;
    logic [DIST_W-1:0] dist_sat;
    t_tag              iss;

    assign np      = (32'(i_points) > MAX_POINTS) ? PTS_W'(MAX_POINTS) : i_points;
    assign nd      = (32'(i_dims) > MAX_DIMS) ? DIMS_W'(MAX_DIMS) : i_dims;
    assign nd_zero = (nd == '0);
    assign d_last  = nd_zero || ((32'(r_d) + 32'd1) == 32'(nd));
    assign p_last  = ((32'(r_p) + 32'd1) == 32'(np));
    assign start   = i_qry.we && i_qry.last && (r_state == S_IDLE);
    assign better  = !r_found || (i_sum <= r_best);

    assign iss.vld   = (r_state == S_RUN);
    assign iss.first = (r_d == '0);
    assign iss.zero  = nd_zero;
    assign iss.last  = d_last;
    assign iss.fin   = d_last && p_last;

    // query buffer and tag
    always_ff @(posedge i_clk) begin
        if (i_qry.we && (32'(i_qry.dim) < MAX_DIMS)) begin
            r_qmem[DW'(i_qry.dim)] <= i_qry.coord[CW-1:0];
        end
        r_qrd <= r_qmem[r_d];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtag <= '0;
        end else if (i_qry.we) begin
            r_qtag <= i_qry.id;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (np == '0) ? S_FIN : S_RUN;
                end
            end
            S_RUN: begin
                if (d_last && p_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_s3.vld && r_s3.fin) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1    <= iss;
            r_s2    <= r_s1;
            r_s3    <= r_s2;
            if (start) begin
                r_found <= 1'b0;
            end else if (r_s3.vld && r_s3.last && better) begin
                r_found <= 1'b1;
            end
        end
    end

    // counters and carried ids
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_p    <= '0;
            r_d    <= '0;
            r_base <= '0;
        end else if (r_state == S_RUN) begin
            if (d_last) begin
                r_d    <= '0;
                r_p    <= r_p + PW'(1);
                r_base <= r_base + AW'(MAX_DIMS);
            end else begin
                r_d <= r_d + DW'(1);
            end
        end
        r_id2 <= i_id_rd;
        r_id3 <= r_id2;
        if (r_s3.vld && r_s3.last && better) begin
            r_best <= i_sum;
            r_bid  <= r_id3;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_coord_addr = r_base + AW'(r_d);
    assign o_id_addr    = r_p;
    assign o_qry_rd     = r_qrd;

    assign o_acc_ctl.vld   = r_s1.vld;
    assign o_acc_ctl.first = r_s1.first;
    assign o_acc_ctl.zero  = r_s1.zero;

    assign dist_ext = CMP_W'(r_best);
    assign dist_sat = (dist_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];

    assign o_res_vld          = (r_state == S_FIN) && i_out_free;
    assign o_res.query_id     = r_qtag;
    assign o_res.nearest_id   = r_found ? r_bid : '0;
    assign o_res.nearest_dist = r_found ? dist_sat : '0;
    assign o_res.found        = r_found;

endmodule

// File: hw/rtl/exhaustive_l1_nearest_neighbor_core.sv
// top level: input handshake, config registers, output register
// a search does one abs-diff accumulate per cycle over every dimension of every
// point in use (one per point with zero dims); with no points it goes to result
// input stalls during a search; loads and query words are taken when not stalled
// synchronous active-low reset clears control; memories are not cleared
// depends on el1nn_pkg, el1nn_refmem, el1nn_absacc, el1nn_seq
module exhaustive_l1_nearest_neighbor_core #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 128,
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [el1nn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [el1nn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [el1nn_pkg::SLOT_W-1:0]        i_slot,
    input  logic [el1nn_pkg::DIM_IN_W-1:0]      i_dim,
    input  logic signed [el1nn_pkg::COORD_IN_W-1:0] i_coord_value,
    input  logic [el1nn_pkg::ID_W-1:0]          i_item_id,
    input  logic                                i_last_of_query,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [el1nn_pkg::ID_W-1:0]          o_query_id,
    output logic [el1nn_pkg::ID_W-1:0]          o_nearest_id,
    output logic [el1nn_pkg::DIST_W-1:0]        o_nearest_dist,
    output logic                                o_found
);
    import el1nn_pkg::*;

    localparam int CW    = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int AW    = (MAX_POINTS * MAX_DIMS > 1) ? $clog2(MAX_POINTS * MAX_DIMS) : 1;
    localparam int SUM_W = CW + $clog2(MAX_DIMS + 1);

    logic [PTS_W-1:0]  r_points;
    logic [DIMS_W-1:0] r_dims;
    logic              r_out_vld;
    t_result           r_out;

    logic              busy, in_acc, out_free, res_vld;
    t_ref_wr           ref_wr;
    t_qry_wr           qry_wr;
    t_acc_ctl          acc_ctl;
    t_result           res;
    logic [AW-1:0]     coord_addr;
    logic [PW-1:0]     id_addr;
    logic [CW-1:0]     coord_rd, qry_rd;
    logic [ID_W-1:0]   id_rd;
    logic [SUM_W-1:0]  sum;

    assign in_acc   = i_in_valid && !busy;
    assign out_free = !r_out_vld || !i_out_stall;

    assign ref_wr.we    = in_acc && (i_kind == KIND_LOAD);
    assign ref_wr.slot  = i_slot;
    assign ref_wr.dim   = i_dim;
    assign ref_wr.coord = i_coord_value;
    assign ref_wr.id    = i_item_id;

    assign qry_wr.we    = in_acc && (i_kind == KIND_QUERY);
    assign qry_wr.last  = i_last_of_query;
    assign qry_wr.dim   = i_dim;
    assign qry_wr.coord = i_coord_value;
    assign qry_wr.id    = i_item_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= POINTS_RST;
            r_dims   <= DIMS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POINTS: r_points <= i_cfg_data;
                CFG_DIMS:   r_dims   <= i_cfg_data[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    el1nn_refmem #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_refmem (
        .i_clk        (i_clk),
        .i_wr         (ref_wr),
        .i_coord_addr (coord_addr),
        .i_id_addr    (id_addr),
        .o_coord_rd   (coord_rd),
        .o_id_rd      (id_rd)
    );

    el1nn_absacc #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_absacc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (acc_ctl),
        .i_qry_coord (qry_rd),
        .i_ref_coord (coord_rd),
        .o_sum       (sum)
    );

    el1nn_seq #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qry        (qry_wr),
        .i_points     (r_points),
        .i_dims       (r_dims),
        .i_out_free   (out_free),
        .o_busy       (busy),
        .o_coord_addr (coord_addr),
        .o_id_addr    (id_addr),
        .i_id_rd      (id_rd),
        .o_qry_rd     (qry_rd),
        .o_acc_ctl    (acc_ctl),
        .i_sum        (sum),
        .o_res_vld    (res_vld),
        .o_res        (res)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign o_in_stall     = busy;
    assign o_out_valid    = r_out_vld;
    assign o_query_id     = r_out.query_id;
    assign o_nearest_id   = r_out.nearest_id;
    assign o_nearest_dist = r_out.nearest_dist;
    assign o_found        = r_out.found;

endmodule

// File: hw/rtl/el1nn_chk.sv
// port-level checker for the nearest neighbor core, with its bind
// depends on el1nn_pkg and exhaustive_l1_nearest_neighbor_core_macros.svh
`include "exhaustive_l1_nearest_neighbor_core_macros.svh"

module el1nn_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_stall,
    input logic                              i_kind,
    input logic                              i_last_of_query,
    input logic                              i_out_valid,
    input logic                              i_out_stall,
    input logic [el1nn_pkg::ID_W-1:0]        i_query_id,
    input logic [el1nn_pkg::ID_W-1:0]        i_nearest_id,
    input logic [el1nn_pkg::DIST_W-1:0]      i_nearest_dist,
    input logic                              i_found
);
    import el1nn_pkg::*;

    `EL1NN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_query_id) && $stable(i_nearest_id) && $stable(i_nearest_dist) && $stable(i_found), "stalled output word changed")
    `EL1NN_ASSERT_IMP(a_not_found, i_clk, i_rst_n, i_out_valid && !i_found, (i_nearest_id == '0) && (i_nearest_dist == '0), "empty result carries nonzero fields")
    `EL1NN_ASSERT_NXT(a_search_stalls, i_clk, i_rst_n, i_in_valid && !i_in_stall && (i_kind == KIND_QUERY) && i_last_of_query, i_in_stall, "input not stalled after search start")
    `EL1NN_ASSERT_IMP(a_result_after_search, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_stall), "result word without a search")

endmodule

bind exhaustive_l1_nearest_neighbor_core el1nn_chk u_el1nn_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .i_in_stall      (o_in_stall),
    .i_kind          (i_kind),
    .i_last_of_query (i_last_of_query),
    .i_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .i_query_id      (o_query_id),
    .i_nearest_id    (o_nearest_id),
    .i_nearest_dist  (o_nearest_dist),
    .i_found         (o_found)
);
